// File: sv/lzss_pkg.sv
package lzss_pkg;

   // History ring and token geometry
   localparam int HISTORY_DEPTH     = 4096;
   localparam int LENGTH_BITS       = 4;
   localparam int INDEX_BITS        = 12;
   localparam int ADDR_BITS         = $clog2(HISTORY_DEPTH);
   localparam int MAX_COPY          = (1 << LENGTH_BITS) - 1;
   localparam int LIT_TOKEN_BITS    = 9;
   localparam int TOKEN_BITS        = 1 + INDEX_BITS + LENGTH_BITS;
   localparam int CNT_BITS          = $clog2(TOKEN_BITS + 1);
   localparam int PIDX_BITS         = $clog2(TOKEN_BITS);
   localparam int WIDE_BITS         = ((INDEX_BITS > ADDR_BITS) ? INDEX_BITS : ADDR_BITS) + 1;

   // Sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PARSE,
      ST_LIT,
      ST_REDUCE,
      ST_READ,
      ST_CAPT,
      ST_APPEND,
      ST_FINISH
   } fsm_state_type;

   // Sequencer to bit parser
   typedef struct packed {
      logic       load;
      logic       clear;
      logic [7:0] packed_byte;
   } par_ctl_type;

   // Bit parser to sequencer
   typedef struct packed {
      logic                   busy;
      logic                   tok_valid;
      logic                   tok_is_lit;
      logic [7:0]             tok_lit;
      logic [INDEX_BITS-1:0]  tok_index;
      logic [LENGTH_BITS-1:0] tok_len;
   } par_stat_type;

   // Sequencer to history ring
   typedef struct packed {
      logic                 rd_en;
      logic [ADDR_BITS-1:0] rd_addr;
      logic                 wr_en;
      logic [7:0]           wr_data;
      logic                 clear;
   } hist_ctl_type;

endpackage

// File: sv/lzss_if.sv
// Compressed input channel
interface lzss_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] packed_byte;
   logic       stream_end;

   modport source (output valid, output packed_byte, output stream_end, input ready);
   modport sink   (input valid, input packed_byte, input stream_end, output ready);
endinterface

// Decompressed result channel
interface lzss_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] plain_byte;
   logic       byte_valid;
   logic       run_last;
   logic       stream_done;

   modport source (output valid, output plain_byte, output byte_valid, output run_last,
                   output stream_done, input ready);
   modport sink   (input valid, input plain_byte, input byte_valid, input run_last,
                   input stream_done, output ready);
endinterface

// File: sv/lzss_bitpar.sv
module lzss_bitpar (
   input  logic                  clock,
   input  logic                  reset,
   input  lzss_pkg::par_ctl_type ctl,
   output lzss_pkg::par_stat_type stat
);

   logic [7:0]                          sh_ff;
   logic [2:0]                          bits_ff;
   logic                                run_ff;
   logic [lzss_pkg::TOKEN_BITS-1:0]     pend_ff;
   logic [lzss_pkg::CNT_BITS-1:0]       pcnt_ff;
   logic                                tokv_ff;
   logic                                islit_ff;
   logic [7:0]                          lit_ff;
   logic [lzss_pkg::INDEX_BITS-1:0]     index_ff;
   logic [lzss_pkg::LENGTH_BITS-1:0]    len_ff;

   logic [lzss_pkg::TOKEN_BITS-1:0]     pend_in;
   logic [lzss_pkg::CNT_BITS-1:0]       pcnt_in;
   logic                                flag;
   logic                                lit_hit;
   logic                                cp_hit;

   // One bit shifted into the token per cycle while the parser runs; flag is the token's first bit
   always_comb begin
      pend_in = {pend_ff[lzss_pkg::TOKEN_BITS-2:0], sh_ff[7]};
      pcnt_in = pcnt_ff + 1'b1;
      flag    = pend_in[pcnt_ff[lzss_pkg::PIDX_BITS-1:0]];
      lit_hit = flag  && (pcnt_in == lzss_pkg::CNT_BITS'(lzss_pkg::LIT_TOKEN_BITS));
      cp_hit  = !flag && (pcnt_in == lzss_pkg::CNT_BITS'(lzss_pkg::TOKEN_BITS));
   end

   // Control and pending-token state
   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         bits_ff <= '0;
         pend_ff <= '0;
         pcnt_ff <= '0;
         tokv_ff <= 1'b0;
      end else if (ctl.clear) begin
         pend_ff <= '0;
         pcnt_ff <= '0;
      end else if (ctl.load) begin
         run_ff  <= 1'b1;
         bits_ff <= '0;
         tokv_ff <= 1'b0;
      end else if (run_ff) begin
         bits_ff <= bits_ff + 1'b1;
         run_ff  <= (bits_ff != 3'd7);
         if (lit_hit || cp_hit) begin
            tokv_ff <= 1'b1;
            pend_ff <= '0;
            pcnt_ff <= '0;
         end else begin
            pend_ff <= pend_in;
            pcnt_ff <= pcnt_in;
         end
      end
   end

   // Byte shifter and captured token fields
   always_ff @(posedge clock) begin
      if (ctl.load) begin
         sh_ff <= ctl.packed_byte;
      end else if (run_ff) begin
         sh_ff <= {sh_ff[6:0], 1'b0};
         if (lit_hit) begin
            islit_ff <= 1'b1;
            lit_ff   <= pend_in[7:0];
         end else if (cp_hit) begin
            islit_ff <= 1'b0;
            index_ff <= pend_in[lzss_pkg::TOKEN_BITS-2:lzss_pkg::LENGTH_BITS];
            len_ff   <= pend_in[lzss_pkg::LENGTH_BITS-1:0];
         end
      end
   end

   assign stat.busy       = run_ff;
   assign stat.tok_valid  = tokv_ff;
   assign stat.tok_is_lit = islit_ff;
   assign stat.tok_lit    = lit_ff;
   assign stat.tok_index  = index_ff;
   assign stat.tok_len    = len_ff;

endmodule

// File: sv/lzss_hist.sv
module lzss_hist (
   input  logic                   clock,
   input  logic                   reset,
   input  lzss_pkg::hist_ctl_type ctl,
   output logic [7:0]             rd_data
);

   logic [7:0]                     ring [lzss_pkg::HISTORY_DEPTH];
   logic [7:0]                     mem_q_ff;
   logic                           rd_ok_ff;
   logic [lzss_pkg::ADDR_BITS-1:0] head_ff;
   logic                           wrapped_ff;
   logic                           head_end;

   assign head_end = (head_ff == lzss_pkg::ADDR_BITS'(lzss_pkg::HISTORY_DEPTH - 1));

   // Ring storage: single write at head, registered read
   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         ring[head_ff] <= ctl.wr_data;
      end
      if (ctl.rd_en) begin
         mem_q_ff <= ring[ctl.rd_addr];
      end
   end

   // Fill tracking: entries below head (or all, once wrapped) hold written data
   always_ff @(posedge clock) begin
      if (reset || ctl.clear) begin
         head_ff    <= '0;
         wrapped_ff <= 1'b0;
         rd_ok_ff   <= 1'b0;
      end else begin
         if (ctl.rd_en) begin
            rd_ok_ff <= wrapped_ff || (ctl.rd_addr < head_ff);
         end
         if (ctl.wr_en) begin
            head_ff <= head_end ? '0 : head_ff + 1'b1;
            if (head_end) begin
               wrapped_ff <= 1'b1;
            end
         end
      end
   end

   // Unwritten entries read as zero
   assign rd_data = rd_ok_ff ? mem_q_ff : 8'h00;

endmodule

// File: sv/lzss_stream_decompressor_core.sv
// Channel | Dir | Payload                                           | Transfer
// req_if  | in  | packed_byte[7:0], stream_end                      | valid & ready
// rsp_if  | out | plain_byte[7:0], byte_valid, run_last, stream_done | valid & ready
//
// Each compressed byte is shifted through the bit parser, with sequencer overhead around it.
// A literal is then emitted and written to the ring; a copy first has its index folded,
// then reads each byte through the single ring read port and captures it, then appends.
// Synchronous active-high reset; the ring is not swept, a fill pointer masks stale
// entries, so the block needs no sweep after reset or after each stream end.
// A stalled result channel holds the sequencer in place; nothing is dropped.
module lzss_stream_decompressor_core (
   input  logic       clock,
   input  logic       reset,
   lzss_req_if.sink   req_if,
   lzss_rsp_if.source rsp_if
);

   lzss_pkg::fsm_state_type          state_ff;
   lzss_pkg::fsm_state_type          state_in;
   logic                             end_ff;
   logic                             emitted_ff;
   logic [lzss_pkg::WIDE_BITS-1:0]   cur_ff;
   logic [lzss_pkg::WIDE_BITS-1:0]   cur_in;
   logic [lzss_pkg::LENGTH_BITS-1:0] cnt_ff;
   logic [lzss_pkg::LENGTH_BITS-1:0] cnt_in;
   logic [7:0]                       hold_ff [lzss_pkg::MAX_COPY];
   logic                             hold_we;

   logic                             ovld_ff;
   logic [7:0]                       obyte_ff;
   logic                             obv_ff;
   logic                             olast_ff;
   logic                             odone_ff;
   logic                             out_load;
   logic [7:0]                       obyte_in;
   logic                             obv_in;
   logic                             olast_in;
   logic                             odone_in;

   lzss_pkg::par_ctl_type            par_ctl;
   lzss_pkg::par_stat_type           par_stat;
   lzss_pkg::hist_ctl_type           hist_ctl;
   logic [7:0]                       hist_q;

   logic                             accept;
   logic                             out_free;
   logic [lzss_pkg::LENGTH_BITS:0]   cnt_nx;
   logic                             cnt_last;
   logic                             need_red;
   logic                             cur_end;
   logic                             do_copy;

   lzss_bitpar u_bitpar (
      .clock (clock),
      .reset (reset),
      .ctl   (par_ctl),
      .stat  (par_stat)
   );

   lzss_hist u_hist (
      .clock   (clock),
      .reset   (reset),
      .ctl     (hist_ctl),
      .rd_data (hist_q)
   );

   // Shared helpers
   assign accept   = req_if.valid && req_if.ready;
   assign out_free = !ovld_ff || rsp_if.ready;
   assign cnt_nx   = {1'b0, cnt_ff} + 1'b1;
   assign cnt_last = (cnt_nx == {1'b0, par_stat.tok_len});
   assign need_red = (cur_ff >= lzss_pkg::WIDE_BITS'(lzss_pkg::HISTORY_DEPTH));
   assign cur_end  = (cur_ff == lzss_pkg::WIDE_BITS'(lzss_pkg::HISTORY_DEPTH - 1));
   assign do_copy  = par_stat.tok_valid && !par_stat.tok_is_lit && (par_stat.tok_len != '0);

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         lzss_pkg::ST_IDLE: begin
            if (accept) state_in = lzss_pkg::ST_PARSE;
         end
         lzss_pkg::ST_PARSE: begin
            if (!par_stat.busy) begin
               if (par_stat.tok_valid && par_stat.tok_is_lit) state_in = lzss_pkg::ST_LIT;
               else if (do_copy)                              state_in = lzss_pkg::ST_REDUCE;
               else                                           state_in = lzss_pkg::ST_FINISH;
            end
         end
         lzss_pkg::ST_LIT: begin
            if (out_free) state_in = lzss_pkg::ST_FINISH;
         end
         lzss_pkg::ST_REDUCE: begin
            if (!need_red) state_in = lzss_pkg::ST_READ;
         end
         lzss_pkg::ST_READ: begin
            state_in = lzss_pkg::ST_CAPT;
         end
         lzss_pkg::ST_CAPT: begin
            if (out_free) state_in = cnt_last ? lzss_pkg::ST_APPEND : lzss_pkg::ST_READ;
         end
         lzss_pkg::ST_APPEND: begin
            if (cnt_last) state_in = lzss_pkg::ST_FINISH;
         end
         lzss_pkg::ST_FINISH: begin
            if (!end_ff || emitted_ff || out_free) state_in = lzss_pkg::ST_IDLE;
         end
         default: state_in = lzss_pkg::ST_IDLE;
      endcase
   end

   // Datapath control per state
   always_comb begin
      req_if.ready        = 1'b0;
      par_ctl.load        = 1'b0;
      par_ctl.clear       = 1'b0;
      par_ctl.packed_byte = req_if.packed_byte;
      hist_ctl.rd_en      = 1'b0;
      hist_ctl.rd_addr    = cur_ff[lzss_pkg::ADDR_BITS-1:0];
      hist_ctl.wr_en      = 1'b0;
      hist_ctl.wr_data    = par_stat.tok_lit;
      hist_ctl.clear      = 1'b0;
      cur_in              = cur_ff;
      cnt_in              = cnt_ff;
      hold_we             = 1'b0;
      out_load            = 1'b0;
      obyte_in            = hist_q;
      obv_in              = 1'b1;
      olast_in            = 1'b1;
      odone_in            = end_ff;
      unique case (state_ff)
         lzss_pkg::ST_IDLE: begin
            req_if.ready = 1'b1;
            par_ctl.load = accept;
         end
         lzss_pkg::ST_PARSE: begin
            cur_in = lzss_pkg::WIDE_BITS'(par_stat.tok_index);
            cnt_in = '0;
         end
         lzss_pkg::ST_LIT: begin
            if (out_free) begin
               out_load       = 1'b1;
               obyte_in       = par_stat.tok_lit;
               hist_ctl.wr_en = 1'b1;
            end
         end
         lzss_pkg::ST_REDUCE: begin
            // index folded into the ring by repeated subtraction
            if (need_red) cur_in = cur_ff - lzss_pkg::WIDE_BITS'(lzss_pkg::HISTORY_DEPTH);
         end
         lzss_pkg::ST_READ: begin
            hist_ctl.rd_en = 1'b1;
         end
         lzss_pkg::ST_CAPT: begin
            if (out_free) begin
               out_load = 1'b1;
               olast_in = cnt_last;
               odone_in = cnt_last && end_ff;
               hold_we  = 1'b1;
               cur_in   = cur_end ? '0 : cur_ff + 1'b1;
               cnt_in   = cnt_last ? '0 : cnt_nx[lzss_pkg::LENGTH_BITS-1:0];
            end
         end
         lzss_pkg::ST_APPEND: begin
            hist_ctl.wr_en   = 1'b1;
            hist_ctl.wr_data = hold_ff[cnt_ff];
            cnt_in           = cnt_nx[lzss_pkg::LENGTH_BITS-1:0];
         end
         lzss_pkg::ST_FINISH: begin
            // stream end: bare marker if nothing went out; wipe history and parser state
            if (end_ff && (emitted_ff || out_free)) begin
               out_load       = !emitted_ff;
               obyte_in       = 8'h00;
               obv_in         = 1'b0;
               odone_in       = 1'b1;
               hist_ctl.clear = 1'b1;
               par_ctl.clear  = 1'b1;
            end
         end
         default: ;
      endcase
   end

   // Sequencer registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= lzss_pkg::ST_IDLE;
         end_ff     <= 1'b0;
         emitted_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (accept) begin
            end_ff     <= req_if.stream_end;
            emitted_ff <= 1'b0;
         end else if (out_load) begin
            emitted_ff <= 1'b1;
         end
      end
   end

   // Copy address, byte counter and copy hold
   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
      cnt_ff <= cnt_in;
      if (hold_we) begin
         hold_ff[cnt_ff] <= hist_q;
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         ovld_ff <= 1'b0;
      end else if (out_load) begin
         ovld_ff <= 1'b1;
      end else if (rsp_if.ready) begin
         ovld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         obyte_ff <= obyte_in;
         obv_ff   <= obv_in;
         olast_ff <= olast_in;
         odone_ff <= odone_in;
      end
   end

   assign rsp_if.valid       = ovld_ff;
   assign rsp_if.plain_byte  = obyte_ff;
   assign rsp_if.byte_valid  = obv_ff;
   assign rsp_if.run_last    = olast_ff;
   assign rsp_if.stream_done = odone_ff;

   // Checks
   a_copy_read: assert property (@(posedge clock) disable iff (reset)
      state_ff == lzss_pkg::ST_READ |-> do_copy)
      else $error("ring read outside a non-empty copy");

   a_accept_parse: assert property (@(posedge clock) disable iff (reset)
      accept |=> par_stat.busy && state_ff == lzss_pkg::ST_PARSE)
      else $error("accepted item did not start the bit parser");

   a_done_last: assert property (@(posedge clock) disable iff (reset)
      ovld_ff && odone_ff |-> olast_ff)
      else $error("stream end flagged on a result that is not the last");

   a_capt_after_read: assert property (@(posedge clock) disable iff (reset)
      state_ff == lzss_pkg::ST_CAPT |->
         $past(state_ff) == lzss_pkg::ST_READ || $past(state_ff) == lzss_pkg::ST_CAPT)
      else $error("capture without a preceding ring read");

endmodule
